### rtl/mp3fw_pkg.sv
// Package: payload types, controller/datapath interface and frame lookup tables
package mp3fw_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [10:0] frame_length;
		logic        mpeg_version;
		logic [15:0] sample_rate_hz;
		logic        padding_bit;
		logic [31:0] total_samples;
		logic        last_of_run;
	} result_t;

	typedef enum logic [2:0] {
		PH_GATHER = 3'b001,
		PH_BODY   = 3'b010,
		PH_STOP   = 3'b100
	} phase_t;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_TOTAL = 1'b1;

	typedef struct packed {
		logic take;
		logic skip_dec;
		logic commit;
		logic out_frame;
		logic out_total;
		logic out_second;
		logic last;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic hdr_full;
		logic hdr_ok;
		logic skip_done;
	} dp_stat_t;

	localparam logic [10:0] SYNC_MASK   = 11'h7FF;
	localparam logic [23:0] TAG_MARK    = 24'h544147;
	localparam logic [10:0] SAMPLES_M1  = 11'd1152;
	localparam logic [10:0] SAMPLES_M2  = 11'd576;
	localparam logic [10:0] HEADER_LEN  = 11'd4;

	// Frame length without padding, indexed by {version, rate index} then bitrate index
	localparam logic [10:0] LEN_TAB [8][16] = '{
		'{11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
		  11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0},
		'{11'd0, 11'd96, 11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
		  11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0},
		'{11'd0, 11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
		  11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0},
		'{11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0,
		  11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0},
		'{11'd0, 11'd26, 11'd52, 11'd78, 11'd104, 11'd130, 11'd156, 11'd182,
		  11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522, 11'd0},
		'{11'd0, 11'd24, 11'd48, 11'd72, 11'd96, 11'd120, 11'd144, 11'd168,
		  11'd192, 11'd240, 11'd288, 11'd336, 11'd384, 11'd432, 11'd480, 11'd0},
		'{11'd0, 11'd36, 11'd72, 11'd108, 11'd144, 11'd180, 11'd216, 11'd252,
		  11'd288, 11'd360, 11'd432, 11'd504, 11'd576, 11'd648, 11'd720, 11'd0},
		'{11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0,
		  11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0}
	};

	function automatic logic [15:0] fs_hz(input logic ver, input logic [1:0] fsi);
		logic [15:0] r;
		case ({ver, fsi})
			3'b000:  r = 16'd44100;
			3'b001:  r = 16'd48000;
			3'b010:  r = 16'd32000;
			3'b100:  r = 16'd22050;
			3'b101:  r = 16'd24000;
			3'b110:  r = 16'd16000;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/mp3fw_dp.sv
// Datapath: header shifter, header check, length lookup, skip counter, sample total, result register
module mp3fw_dp import mp3fw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output result_t  result
);

	logic [23:0] hdr_q;
	logic [1:0]  cnt_q;
	logic [10:0] skip_q;
	logic [31:0] total_q;
	result_t     res_q;

	logic [31:0] hdr;
	logic        ver;
	logic [3:0]  bri;
	logic [1:0]  fsi;
	logic        pad;
	logic [10:0] len;
	logic [15:0] fs;
	logic [10:0] add;
	logic [32:0] sum;
	logic [31:0] total_next;

	always_comb begin
		hdr = {hdr_q, item.data_byte};
		ver = (hdr[20:19] == 2'b10);
		bri = hdr[15:12];
		fsi = hdr[11:10];
		pad = hdr[9];
		len = LEN_TAB[{ver, fsi}][bri] + {10'd0, pad};
		fs  = fs_hz(ver, fsi);
		add = ver ? SAMPLES_M2 : SAMPLES_M1;
		sum = {1'b0, total_q} + {22'd0, add};
		total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

		stat.hdr_full  = (cnt_q == 2'd3);
		stat.hdr_ok    = (hdr[31:21] == SYNC_MASK) && (hdr[31:8] != TAG_MARK) && hdr[20]
			&& (bri != 4'h0) && (bri != 4'hF) && (fsi != 2'b11);
		stat.skip_done = (skip_q <= 11'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= '0;
			cnt_q   <= '0;
			skip_q  <= '0;
			total_q <= '0;
		end else if (cmd.clear) begin
			hdr_q   <= '0;
			cnt_q   <= '0;
			skip_q  <= '0;
			total_q <= '0;
		end else begin
			if (cmd.take) begin
				hdr_q <= hdr[23:0];
				cnt_q <= cnt_q + 2'd1;
			end
			if (cmd.commit) begin
				skip_q  <= len - HEADER_LEN;
				total_q <= total_next;
			end
			if (cmd.skip_dec) begin
				skip_q <= stat.skip_done ? 11'd0 : skip_q - 11'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_frame) begin
			res_q.kind           <= KIND_FRAME;
			res_q.frame_length   <= len;
			res_q.mpeg_version   <= ver;
			res_q.sample_rate_hz <= fs;
			res_q.padding_bit    <= pad;
			res_q.total_samples  <= total_next;
			res_q.last_of_run    <= cmd.last;
		end else if (cmd.out_total) begin
			res_q.kind           <= KIND_TOTAL;
			res_q.frame_length   <= '0;
			res_q.mpeg_version   <= 1'b0;
			res_q.sample_rate_hz <= '0;
			res_q.padding_bit    <= 1'b0;
			res_q.total_samples  <= total_q;
			res_q.last_of_run    <= 1'b1;
		end else if (cmd.out_second) begin
			// total follows the frame result of the same byte; total already in place
			res_q.kind           <= KIND_TOTAL;
			res_q.frame_length   <= '0;
			res_q.mpeg_version   <= 1'b0;
			res_q.sample_rate_hz <= '0;
			res_q.padding_bit    <= 1'b0;
			res_q.last_of_run    <= 1'b1;
		end
	end

	assign result = res_q;

endmodule

### rtl/mp3fw_ctrl.sv
// Controller: parse phase state machine and result handshake
module mp3fw_ctrl import mp3fw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	input  logic     end_of_stream,
	input  logic     result_ready,
	input  dp_stat_t stat,
	output logic     byte_ready,
	output logic     result_valid,
	output dp_cmd_t  cmd
);

	phase_t phase_q, phase_d;
	logic   valid_q, valid_d;
	logic   pend_q, pend_d;
	logic   acc;
	logic   stop_now;
	logic   pend_set;

	assign byte_ready   = !valid_q;
	assign result_valid = valid_q;
	assign acc          = byte_valid && byte_ready;

	always_comb begin
		cmd      = '0;
		phase_d  = phase_q;
		stop_now = 1'b0;
		pend_set = 1'b0;
		valid_d  = valid_q;
		pend_d   = pend_q;

		if (acc) begin
			unique case (phase_q)
				PH_GATHER: begin
					cmd.take = 1'b1;
					if (stat.hdr_full) begin
						if (stat.hdr_ok) begin
							cmd.commit    = 1'b1;
							cmd.out_frame = 1'b1;
							phase_d       = PH_BODY;
						end else begin
							cmd.out_total = 1'b1;
							phase_d       = PH_STOP;
							stop_now      = 1'b1;
						end
					end
				end
				PH_BODY: begin
					cmd.skip_dec = 1'b1;
					if (stat.skip_done) begin
						phase_d = PH_GATHER;
					end
				end
				PH_STOP: begin
				end
				default: begin
					phase_d = PH_GATHER;
				end
			endcase

			if (end_of_stream) begin
				if (phase_q != PH_STOP && !stop_now) begin
					if (cmd.out_frame) begin
						pend_set = 1'b1;
					end else begin
						cmd.out_total = 1'b1;
					end
				end
				cmd.clear = 1'b1;
				phase_d   = PH_GATHER;
			end

			cmd.last = !pend_set;
			if (cmd.out_frame || cmd.out_total) begin
				valid_d = 1'b1;
				pend_d  = pend_set;
			end
		end else if (valid_q && result_ready) begin
			if (pend_q) begin
				cmd.out_second = 1'b1;
				pend_d         = 1'b0;
			end else begin
				valid_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GATHER;
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			valid_q <= valid_d;
			pend_q  <= pend_d;
		end
	end

endmodule

### rtl/mp3_frame_walker.sv
// Top level: MP3 frame header walker, one stream byte per transaction
//
//   channel  direction  handshake                    payload
//   byte     in         byte_valid / byte_ready      byte_data   (in_item_t)
//   result   out        result_valid / result_ready  result_data (result_t)
//
// A byte that gives no result leaves byte_ready high, so body bytes stream at one per cycle.
// The byte after one that gives results waits until they drain from the single output
// register, each result waiting on result_ready; a frame header at stream end gives two
// results.
// byte_ready is low whenever a result sits in the output register.
// Asynchronous reset puts the walker in header gathering with a zero total; no clearing pass.
module mp3_frame_walker import mp3fw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  in_item_t byte_data,
	output logic     result_valid,
	input  logic     result_ready,
	output result_t  result_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mp3fw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.end_of_stream(byte_data.end_of_stream),
		.result_ready (result_ready),
		.stat         (stat),
		.byte_ready   (byte_ready),
		.result_valid (result_valid),
		.cmd          (cmd)
	);

	mp3fw_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (byte_data),
		.cmd   (cmd),
		.stat  (stat),
		.result(result_data)
	);

`ifndef NO_ASSERTIONS
	a_no_take_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !byte_ready)
		else $error("byte taken while a result is pending");

	a_frame_then_total: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready && result_data.kind == KIND_FRAME
			&& !result_data.last_of_run)
		|=> (result_valid && result_data.kind == KIND_TOTAL && result_data.last_of_run))
		else $error("frame result not followed by its total");

	a_total_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.kind == KIND_TOTAL)
		|-> (result_data.frame_length == 11'd0 && result_data.sample_rate_hz == 16'd0
			&& result_data.last_of_run))
		else $error("total result with frame fields set");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.out_frame, cmd.out_total, cmd.out_second}) <= 1)
		else $error("result register loaded from two sources");
`endif

endmodule
